// File: hw/rtl/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned SIZE_BITS = 13;
  localparam int unsigned BTN_BITS  = 3;
  localparam int unsigned IDX_BITS  = 2;

  localparam logic [BYTE_BITS-1:0] SYNC_BIT    = 8'h08;
  localparam logic [BYTE_BITS-1:0] X_OVF_BIT   = 8'h40;
  localparam logic [BYTE_BITS-1:0] Y_OVF_BIT   = 8'h80;
  localparam logic [BYTE_BITS-1:0] BUTTON_MASK = 8'h07;

  localparam logic [SIZE_BITS-1:0] DEFAULT_WIDTH  = 13'd640;
  localparam logic [SIZE_BITS-1:0] DEFAULT_HEIGHT = 13'd480;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    BYTE_HEAD,
    BYTE_X,
    BYTE_Y
  } byte_pos_e;

  // One assembled packet.
  typedef struct packed {
    logic [BYTE_BITS-1:0] header;
    logic [BYTE_BITS-1:0] x_byte;
    logic [BYTE_BITS-1:0] y_byte;
  } pkt_t;

endpackage

// File: hw/rtl/mpct_assembler.sv
// Byte framer: syncs on the header byte and assembles three-byte packets.
module mpct_assembler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  output logic          in_stall_o,
  output logic          pkt_valid_o,
  output mpct_pkg::pkt_t pkt_o,
  input  logic          pkt_take_i
);
  import mpct_pkg::*;

  byte_pos_e            state_q, state_d;
  logic [BYTE_BITS-1:0] header_q, header_d;
  logic [BYTE_BITS-1:0] x_byte_q, x_byte_d;
  pkt_t                 pkt_q, pkt_d;
  logic                 pkt_valid_q, pkt_valid_d;
  logic                 accept;

  // Hold the input only when a finished packet cannot move on.
  assign in_stall_o = pkt_valid_q && !pkt_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BYTE_HEAD;
      pkt_valid_q <= 1'b0;
      header_q    <= '0;
      x_byte_q    <= '0;
    end else begin
      state_q     <= state_d;
      pkt_valid_q <= pkt_valid_d;
      header_q    <= header_d;
      x_byte_q    <= x_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  always_comb begin
    state_d     = state_q;
    header_d    = header_q;
    x_byte_d    = x_byte_q;
    pkt_d       = pkt_q;
    pkt_valid_d = pkt_valid_q && !pkt_take_i;
    if (accept) begin
      unique case (state_q)
        BYTE_HEAD: begin
          // Drop bytes without the sync bit while hunting for a header.
          if ((data_byte_i & SYNC_BIT) != '0) begin
            header_d = data_byte_i;
            state_d  = BYTE_X;
          end
        end
        BYTE_X: begin
          x_byte_d = data_byte_i;
          state_d  = BYTE_Y;
        end
        BYTE_Y: begin
          pkt_d.header = header_q;
          pkt_d.x_byte = x_byte_q;
          pkt_d.y_byte = data_byte_i;
          pkt_valid_d  = 1'b1;
          state_d      = BYTE_HEAD;
        end
        default: begin
          state_d = BYTE_HEAD;
        end
      endcase
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

  a_third_byte_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && state_q == BYTE_Y |=> pkt_valid_q && state_q == BYTE_HEAD)
    else $error("third byte did not produce a packet");

  a_no_sync_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && state_q == BYTE_HEAD && (data_byte_i & SYNC_BIT) == '0
    |=> state_q == BYTE_HEAD)
    else $error("byte without sync bit left header hunt");

  a_pending_packet_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_q && !pkt_take_i |=> pkt_valid_q)
    else $error("packet lost before it was taken");

endmodule

// File: hw/rtl/mpct_cursor.sv
// Cursor update: applies packet deltas, clamps to the screen and holds the result.
module mpct_cursor #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned PW         = 12,
  parameter int unsigned SW         = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pkt_valid_i,
  input  mpct_pkg::pkt_t        pkt_i,
  output logic                  pkt_take_o,
  input  logic [SW-1:0]         width_i,
  input  logic [SW-1:0]         height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic [2:0]            buttons_o
);
  import mpct_pkg::*;

  localparam int unsigned CW = PW + SW + 3;

  logic [PW-1:0]       pos_x_q, pos_x_d;
  logic [PW-1:0]       pos_y_q, pos_y_d;
  logic [BTN_BITS-1:0] buttons_q;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_BITS-1:0] dx, dy;
  logic signed [PW+1:0] sum_x, sum_y;
  logic signed [CW-1:0] ext_x, ext_y, lim_x, lim_y;
  logic [CW-1:0]        clamp_x, clamp_y;

  assign pkt_take_o = pkt_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    // Zero a delta whose overflow flag is set.
    dx = ((pkt_i.header & X_OVF_BIT) != '0) ? '0 : pkt_i.x_byte;
    dy = ((pkt_i.header & Y_OVF_BIT) != '0) ? '0 : pkt_i.y_byte;
    sum_x = $signed({2'b00, pos_x_q}) + $signed({{(PW-6){dx[7]}}, dx});
    sum_y = $signed({2'b00, pos_y_q}) - $signed({{(PW-6){dy[7]}}, dy});
    ext_x = {{(CW-PW-2){sum_x[PW+1]}}, sum_x};
    ext_y = {{(CW-PW-2){sum_y[PW+1]}}, sum_y};
    lim_x = $signed({{(CW-SW){1'b0}}, width_i});
    lim_y = $signed({{(CW-SW){1'b0}}, height_i});
    if (ext_x < 0) begin
      clamp_x = '0;
    end else if (ext_x >= lim_x) begin
      clamp_x = lim_x - CW'(1);
    end else begin
      clamp_x = ext_x;
    end
    if (ext_y < 0) begin
      clamp_y = '0;
    end else if (ext_y >= lim_y) begin
      clamp_y = lim_y - CW'(1);
    end else begin
      clamp_y = ext_y;
    end
    pos_x_d     = pkt_take_o ? clamp_x[PW-1:0] : pos_x_q;
    pos_y_d     = pkt_take_o ? clamp_y[PW-1:0] : pos_y_q;
    out_valid_d = pkt_take_o || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= PW'(DEFAULT_WIDTH >> 1);
      pos_y_q     <= PW'(DEFAULT_HEIGHT >> 1);
    end else begin
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_take_o) begin
      buttons_q <= pkt_i.header[BTN_BITS-1:0];
    end
  end

  // The position registers double as the result payload; they move only on a take.
  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = pos_x_q[COORD_BITS-1:0];
  assign cursor_y_o  = pos_y_q[COORD_BITS-1:0];
  assign buttons_o   = buttons_q;

  a_take_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_take_o |=> out_valid_q)
    else $error("taken packet did not reach the output");

  a_x_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_take_o |=> {{(CW-PW){1'b0}}, pos_x_q} < {{(CW-SW){1'b0}}, $past(width_i)})
    else $error("cursor x outside the screen");

  a_y_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_take_o |=> {{(CW-PW){1'b0}}, pos_y_q} < {{(CW-SW){1'b0}}, $past(height_i)})
    else $error("cursor y outside the screen");

endmodule

// File: hw/rtl/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker: top level with screen size registers.
//
// Usage: feed raw mouse bytes on the input channel (in_valid_i, data_byte_i,
// in_stall_o). Bytes are framed into three-byte packets; while hunting for a
// header, bytes without the sync bit (bit 3) are dropped. Each complete
// packet yields one item on the output channel (out_valid_o, cursor_x_o,
// cursor_y_o, buttons_o, out_stall_i) after its third byte has passed
// through the packet register and then the cursor/output register.
// Throughput is one byte per cycle while in_stall_o is low; the cursor
// unit's add-and-clamp is the only arithmetic between these registers.
// When the receiver stalls, the result holds and one more packet waits in
// the packet register; in_stall_o rises while that waiting packet cannot
// move on, whatever byte comes next.
// Screen width and height are written through the cfg port (index 0 and 1),
// by the user only while no item is in flight; the block does not enforce
// it. A size of zero selects the default 640 x 480; sizes above 2^COORD_BITS
// are limited to it. Reset selects a 640 x 480 screen, puts the cursor at its
// center and empties both pipeline registers.
module mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            data_byte_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic [2:0]            buttons_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [12:0]           cfg_data_i
);
  import mpct_pkg::*;

  localparam int unsigned PW = (COORD_BITS < 10) ? 10 : COORD_BITS;
  localparam int unsigned SW = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
  localparam int unsigned LIMIT = 2 ** COORD_BITS;
  localparam logic [SW-1:0] SIZE_LIMIT = SW'(LIMIT);
  localparam logic [SW-1:0] RST_WIDTH  = (640 > LIMIT) ? SW'(LIMIT) : SW'(640);
  localparam logic [SW-1:0] RST_HEIGHT = (480 > LIMIT) ? SW'(LIMIT) : SW'(480);

  logic [SW-1:0] width_q, width_d;
  logic [SW-1:0] height_q, height_d;
  logic [SW-1:0] cfg_size;
  logic [SW-1:0] cfg_fallback;
  logic          cfg_write;
  logic          pkt_valid;
  logic          pkt_take;
  pkt_t          pkt;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Store the effective size: zero picks the default, large values saturate.
  always_comb begin
    cfg_fallback = (cfg_index_i == REG_SCREEN_WIDTH) ? SW'(DEFAULT_WIDTH)
                                                     : SW'(DEFAULT_HEIGHT);
    cfg_size = (cfg_data_i == '0) ? cfg_fallback : SW'(cfg_data_i);
    if (cfg_size > SIZE_LIMIT) begin
      cfg_size = SIZE_LIMIT;
    end
    width_d  = width_q;
    height_d = height_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_d  = cfg_size;
        REG_SCREEN_HEIGHT: height_d = cfg_size;
        default: begin
          width_d = width_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  mpct_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .in_stall_o  (in_stall_o),
    .pkt_valid_o (pkt_valid),
    .pkt_o       (pkt),
    .pkt_take_i  (pkt_take)
  );

  mpct_cursor #(
    .COORD_BITS (COORD_BITS),
    .PW         (PW),
    .SW         (SW)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_valid),
    .pkt_i       (pkt),
    .pkt_take_o  (pkt_take),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o),
    .buttons_o   (buttons_o)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the mouse packet cursor tracker.
`timescale 1ns / 100ps

module tb_top;
  import mpct_pkg::*;

  localparam int COORD = 12;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [COORD-1:0] x;
    logic [COORD-1:0] y;
    logic [2:0]       btn;
  } cursor_rpt_t;

  // Opening bytes: dropped heads, delta extremes, all buttons, each overflow
  // flag, sign flags that must be ignored, and a closing all-ones packet.
  localparam logic [7:0] OPENING [26] = '{
    8'h00, 8'hF7,
    8'h08, 8'h7F, 8'h80,
    8'h0F, 8'h80, 8'h7F,
    8'hC8, 8'h55, 8'hAA,
    8'h48, 8'h10, 8'h10,
    8'h88, 8'hFF, 8'h01,
    8'h38, 8'h01, 8'hFF,
    8'h09, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [7:0]       data_byte_i = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [COORD-1:0] cursor_x_o;
  logic [COORD-1:0] cursor_y_o;
  logic [2:0]       buttons_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [12:0]      cfg_data_i = '0;

  mouse_packet_cursor_tracker #(.COORD_BITS(COORD)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o),
    .buttons_o   (buttons_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Tracker shadow state
  byte_pos_e        pkt_pos = BYTE_HEAD;
  logic [7:0]       pkt_hdr = '0;
  logic [7:0]       pkt_xb = '0;
  logic [COORD-1:0] cur_x = COORD'(DEFAULT_WIDTH / 2);
  logic [COORD-1:0] cur_y = COORD'(DEFAULT_HEIGHT / 2);
  logic [12:0]      scr_w = DEFAULT_WIDTH;
  logic [12:0]      scr_h = DEFAULT_HEIGHT;

  logic [7:0]  byte_q[$];
  cursor_rpt_t cursor_q[$];
  cursor_rpt_t want;
  bit          byte_in_flight = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int          hold_cycles = 0;
  int          err_cnt = 0;

  function automatic int screen_span(logic [12:0] size_reg, logic [12:0] fallback);
    int span;
    span = (size_reg == 0) ? int'(fallback) : int'(size_reg);
    if (span > (1 << COORD)) span = 1 << COORD;
    return span;
  endfunction

  function automatic logic [COORD-1:0] move_clamped(logic [COORD-1:0] pos, int delta,
                                                     int span);
    int p;
    p = int'(pos) + delta;
    if (p < 0) p = 0;
    if (p >= span) p = span - 1;
    return COORD'(p);
  endfunction

  function automatic int draw_gap(bit idle_on);
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Advance the packet framer by one accepted byte; queue a report on the third.
  task automatic track_byte(input logic [7:0] b);
    int dx;
    int dy;
    cursor_rpt_t rpt;
    case (pkt_pos)
      BYTE_HEAD: begin
        if ((b & SYNC_BIT) != 0) begin
          pkt_hdr = b;
          pkt_pos = BYTE_X;
        end
      end
      BYTE_X: begin
        pkt_xb = b;
        pkt_pos = BYTE_Y;
      end
      default: begin
        pkt_pos = BYTE_HEAD;
        dx = ((pkt_hdr & X_OVF_BIT) != 0) ? 0 : int'($signed(pkt_xb));
        dy = ((pkt_hdr & Y_OVF_BIT) != 0) ? 0 : int'($signed(b));
        cur_x = move_clamped(cur_x, dx, screen_span(scr_w, DEFAULT_WIDTH));
        cur_y = move_clamped(cur_y, -dy, screen_span(scr_h, DEFAULT_HEIGHT));
        rpt.x = cur_x;
        rpt.y = cur_y;
        rpt.btn = 3'(pkt_hdr & BUTTON_MASK);
        cursor_q.push_back(rpt);
      end
    endcase
  endtask

  // Byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_byte(data_byte_i);
        byte_in_flight = 1'b0;
        send_gap = draw_gap(send_idle_on);
      end
      if (!byte_in_flight) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0) begin
          data_byte_i <= byte_q.pop_front();
          in_valid_i <= 1'b1;
          byte_in_flight = 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Cursor report monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (cursor_q.size() == 0) begin
          $error("unexpected cursor report x=%0d y=%0d buttons=%0d",
                 cursor_x_o, cursor_y_o, buttons_o);
          err_cnt++;
        end else begin
          want = cursor_q.pop_front();
          if (cursor_x_o !== want.x) begin
            $error("cursor_x expected %0d actual %0d", want.x, cursor_x_o);
            err_cnt++;
          end
          if (cursor_y_o !== want.y) begin
            $error("cursor_y expected %0d actual %0d", want.y, cursor_y_o);
            err_cnt++;
          end
          if (buttons_o !== want.btn) begin
            $error("buttons expected %0d actual %0d", want.btn, buttons_o);
            err_cnt++;
          end
        end
        recv_gap = draw_gap(recv_idle_on);
      end
      if (!long_hold_req) begin
        hold_cycles = 0;
        long_hold_done = 1'b0;
      end
      if (long_hold_req && !long_hold_done) begin
        hold_cycles++;
        if (hold_cycles >= HOLD_CYCLES) long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  // Wait for every queued byte and every expected report, then let the pipe settle.
  task automatic drain();
    while (byte_q.size() != 0 || byte_in_flight || cursor_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    byte_q.push_back(hdr);
    byte_q.push_back(xb);
    byte_q.push_back(yb);
  endtask

  // Mostly well-formed packets with random content, some stray bytes between.
  task automatic push_stream(input int n);
    int cnt;
    logic [7:0] hdr;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 8) begin
        hdr = 8'($urandom_range(0, 255)) | SYNC_BIT;
        if ($urandom_range(0, 3) != 0) hdr = hdr & ~X_OVF_BIT;
        if ($urandom_range(0, 3) != 0) hdr = hdr & ~Y_OVF_BIT;
        push_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        cnt += 3;
      end else begin
        byte_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic set_screen(input logic [12:0] w, input logic [12:0] h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  function automatic logic [12:0] pick_size();
    if ($urandom_range(0, 3) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 64));
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPENING[i]) byte_q.push_back(OPENING[i]);
    drain();

    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    set_screen(13'd1, 13'd1);
    push_stream(120);
    drain();

    // Walk the cursor into both corners of the largest screen.
    set_screen(13'd4096, 13'd4096);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (35) push_packet(8'h08, 8'h80, 8'h7F);
    repeat (35) push_packet(8'h08, 8'h7F, 8'h80);
    push_stream(120);
    drain();

    // Cursor sits far outside the fallback screen now.
    set_screen(13'd0, 13'd0);
    send_idle_on = 1'b1;
    push_stream(120);
    drain();

    set_screen(13'd8191, 13'd4097);
    recv_idle_on = 1'b1;
    send_idle_on = 1'b0;
    push_stream(120);
    drain();

    // Fill the pipe against a long receiver hold.
    long_hold_req = 1'b1;
    recv_idle_on = 1'b0;
    push_stream(60);
    drain();
    long_hold_req = 1'b0;

    set_screen(13'd2, 13'd3);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    push_stream(120);
    drain();

    set_screen(13'd100, 13'd50);
    push_stream(120);
    drain();

    for (int k = 0; k < 2; k++) begin
      set_screen(pick_size(), pick_size());
      send_idle_on = k[0];
      recv_idle_on = !k[0];
      push_stream(120);
      drain();
    end

    if (err_cnt == 0 && cursor_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
